[rtl/sps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// Shared widths, operation codes and types of the sorted pair-sum search.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int OP_W  = 2;
	localparam int VAL_W = 32;
	localparam int KEY_W = 33;
	localparam int POS_W = 10;

	// operation codes of an input transaction
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	typedef logic        [OP_W-1:0]  op_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic        [POS_W-1:0] pos_t;

	typedef struct packed {
		logic found;
		pos_t low_position;
		pos_t high_position;
		val_t low_value;
		val_t high_value;
	} result_t;

endpackage

[rtl/sps_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_in_if
// Input channel: valid/ready handshake carrying one operation transaction.
// ----------------------------------------------------------------------------
interface sps_in_if import sps_pkg::*; ();
	logic valid;
	logic ready;
	op_t  operation;
	val_t element;
	key_t key;

	modport source (output valid, output operation, output element, output key,
		input ready);
	modport sink (input valid, input operation, input element, input key,
		output ready);
endinterface

[rtl/sps_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_out_if
// Result channel: valid/ready handshake carrying one search answer.
// ----------------------------------------------------------------------------
interface sps_out_if import sps_pkg::*; ();
	logic valid;
	logic ready;
	logic found;
	pos_t low_position;
	pos_t high_position;
	val_t low_value;
	val_t high_value;

	modport source (output valid, output found, output low_position,
		output high_position, output low_value, output high_value, input ready);
	modport sink (input valid, input found, input low_position,
		input high_position, input low_value, input high_value, output ready);
endinterface

[rtl/sps_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_store
// Value memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module sps_store import sps_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  val_t                     wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_lo_addr,
	input  logic [$clog2(DEPTH)-1:0] rd_hi_addr,
	output val_t                     rd_lo_data,
	output val_t                     rd_hi_data
);

	val_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// two read ports, registered read data
	always_ff @(posedge clk) begin
		rd_lo_data <= mem[rd_lo_addr];
		rd_hi_data <= mem[rd_hi_addr];
	end

endmodule

[rtl/sorted_pair_sum_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_pair_sum_search
// Stores signed values the user must append in ascending order (unchecked),
// and finds two distinct entries summing exactly to a key with two pointers.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         handshake
//  item     in   operation, element, key                         valid/ready
//  result   out  found, low_position, high_position,             valid/ready
//                low_value, high_value
//
//  item.ready is high whenever no search is under way. A search makes no
//  pointer steps for fewer than two entries and entry count - 1 on a miss;
//  the two-port store read, one pair per cycle, sets the step rate.
//  A result waiting on result.ready holds the next search in its last cycle,
//  with item.ready low; otherwise clears and appends still go through.
//  Reset clears the entry count, the state and result.valid; no sweep of
//  the store is needed.
// ----------------------------------------------------------------------------
module sorted_pair_sum_search import sps_pkg::*; #(
	parameter int STORE_DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	sps_in_if.sink    item,
	sps_out_if.source result
);

	localparam int PTR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] lo_q, hi_q;
	logic [PTR_W-1:0] lo_n, hi_n;
	logic [PTR_W-1:0] rd_lo_addr, rd_hi_addr;
	key_t             key_q;
	val_t             rd_lo, rd_hi;
	logic signed [KEY_W-1:0] sum;
	logic             hit, miss;
	result_t          pend_q, out_q;
	logic             out_valid_q;
	logic             accept, out_free;
	logic             do_append, do_search, short_store;
	pos_t             lo_pos, hi_pos;

	assign accept      = item.valid && item.ready;
	assign item.ready  = (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || result.ready;
	assign do_append   = accept && (item.operation == OP_APPEND)
		&& (cnt_q < CNT_W'(STORE_DEPTH));
	assign do_search   = accept && (item.operation == OP_SEARCH);
	assign short_store = (cnt_q < CNT_W'(2));

	// value store
	sps_store #(.DEPTH(STORE_DEPTH)) u_store (
		.clk        (clk),
		.wr_en      (do_append),
		.wr_addr    (cnt_q[PTR_W-1:0]),
		.wr_data    (item.element),
		.rd_lo_addr (rd_lo_addr),
		.rd_hi_addr (rd_hi_addr),
		.rd_lo_data (rd_lo),
		.rd_hi_data (rd_hi)
	);

	// exact pair sum and pointer step
	assign sum = $signed({rd_lo[VAL_W-1], rd_lo}) + $signed({rd_hi[VAL_W-1], rd_hi});

	always_comb begin
		hit  = (sum == key_q);
		lo_n = lo_q;
		hi_n = hi_q;
		if (!hit) begin
			if (sum > key_q) begin
				hi_n = hi_q - PTR_W'(1);
			end else begin
				lo_n = lo_q + PTR_W'(1);
			end
		end
		miss = !hit && (lo_n == hi_n);
	end

	// read addresses: first pair on accept, next pair while walking
	always_comb begin
		if (state_q == ST_WALK) begin
			rd_lo_addr = lo_n;
			rd_hi_addr = hi_n;
		end else begin
			rd_lo_addr = '0;
			rd_hi_addr = PTR_W'(cnt_q - CNT_W'(1));
		end
	end

	// pointer positions onto the result field width
	generate
		if (PTR_W >= POS_W) begin : g_pos_trunc
			assign lo_pos = lo_q[POS_W-1:0];
			assign hi_pos = hi_q[POS_W-1:0];
		end else begin : g_pos_ext
			assign lo_pos = {{(POS_W-PTR_W){1'b0}}, lo_q};
			assign hi_pos = {{(POS_W-PTR_W){1'b0}}, hi_q};
		end
	endgenerate

	// control: state, entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (item.operation == OP_CLEAR)) begin
						cnt_q <= '0;
					end
					if (do_append) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (do_search) begin
						state_q <= short_store ? ST_DRAIN : ST_WALK;
					end
				end
				ST_WALK: begin
					if (hit || miss) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search datapath: key, pointers, pending answer
	always_ff @(posedge clk) begin
		if (do_search) begin
			key_q  <= item.key;
			lo_q   <= '0;
			hi_q   <= PTR_W'(cnt_q - CNT_W'(1));
			pend_q <= '0;
		end else if (state_q == ST_WALK) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
			if (hit) begin
				pend_q <= '{found: 1'b1, low_position: lo_pos, high_position: hi_pos,
					low_value: rd_lo, high_value: rd_hi};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DRAIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN && out_free) begin
			out_q <= pend_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.found         = out_q.found;
	assign result.low_position  = out_q.low_position;
	assign result.high_position = out_q.high_position;
	assign result.low_value     = out_q.low_value;
	assign result.high_value    = out_q.high_value;

	// checks
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (lo_q < hi_q))
		else $error("pointers crossed during walk");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STORE_DEPTH))
		else $error("entry count above store depth");

	a_drain_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("pending answer not moved to output");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.found) |-> (out_q.low_position == '0
		&& out_q.high_position == '0 && out_q.low_value == '0
		&& out_q.high_value == '0))
		else $error("not-found answer carries data");

	a_hit_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && hit) |=> (pend_q.found
		&& ($signed({pend_q.low_value[VAL_W-1], pend_q.low_value})
		+ $signed({pend_q.high_value[VAL_W-1], pend_q.high_value})) == key_q))
		else $error("match captured with wrong pair");

endmodule
